// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define FCRD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");
`define FCRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define FCRD_ASSERT(lbl, prop)
`define FCRD_ASSERT_IMPL(lbl, ante, cons)
`define FCRD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hdl/fcrd_pkg.sv -----
// Types and constants of the FastCGI record session deframer.
package fcrd_pkg;

  localparam logic [7:0] TYPE_BEGIN_REQUEST = 8'd1;
  localparam logic [7:0] TYPE_PARAMS        = 8'd4;
  localparam logic [7:0] TYPE_STDIN         = 8'd5;
  localparam int unsigned FCGI_KEEP_CONN_BIT = 0;

  localparam logic [15:0] BEGIN_BODY_LEN = 16'd8;

  // configuration register indexes
  localparam logic REG_EXPECTED_VERSION = 1'b0;
  localparam logic REG_ACCEPTED_ROLE    = 1'b1;

  localparam logic [7:0] EXPECTED_VERSION_RST = 8'd1;
  localparam logic [7:0] ACCEPTED_ROLE_RST    = 8'd1;

  // byte classification codes
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_PARAMS  = 3'd1;
  localparam logic [2:0] KIND_STDIN   = 3'd2;
  localparam logic [2:0] KIND_IGNORED = 3'd3;
  localparam logic [2:0] KIND_PADDING = 3'd4;
  localparam logic [2:0] KIND_DROPPED = 3'd5;

  localparam logic [2:0] HDR_LAST_IDX = 3'd7;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_CONTENT = 3'b010,
    PH_PADDING = 3'b100
  } phase_e;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  data_out;
    logic [15:0] session_request_id;
    logic [7:0]  record_kind;
    logic        last_content;
    logic        session_started;
    logic        keep_connection;
    logic        request_done;
    logic        version_error;
    logic        connection_closed;
  } result_t;

endpackage

// ----- hdl/fcrd_if.sv -----
// Stream interfaces for the input byte word and the result word.
interface fcrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface fcrd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  data_out;
  logic [15:0] session_request_id;
  logic [7:0]  record_kind;
  logic        last_content;
  logic        session_started;
  logic        keep_connection;
  logic        request_done;
  logic        version_error;
  logic        connection_closed;

  modport source (
    output valid, output byte_kind, output data_out, output session_request_id,
    output record_kind, output last_content, output session_started,
    output keep_connection, output request_done, output version_error,
    output connection_closed, input ready
  );
  modport sink (
    input valid, input byte_kind, input data_out, input session_request_id,
    input record_kind, input last_content, input session_started,
    input keep_connection, input request_done, input version_error,
    input connection_closed, output ready
  );
endinterface

// ----- hdl/fastcgi_record_session_deframer_top.sv -----
// FastCGI record deframer and single-request session tracker, top level.
//
// in_i carries the raw connection stream, one byte per word. out_o gives one
// result word per input word: the byte's classification, the byte itself, the
// session id and keep flag, the record type and the session/error flags.
// cfg_we_i/cfg_idx_i/cfg_data_i write expected_version (index 0) and
// accepted_role (index 1); write them only while no word is in flight.
// The result of a word accepted at a clock edge is registered and appears on
// out_o in the cycle after that edge. One word per cycle while the receiver
// takes every result word; the parser state is updated in the same cycle the
// word is accepted, so the only limit is the single output register.
// Reset clears the parser to the header phase, closes the session, clears the
// error and stop flags and loads both registers with 1.
// When the receiver stalls, the result word is held and in_i.ready drops; it
// rises again in the cycle the held word is taken.
// After a version error or a non-keep request completion the block stops:
// later bytes are still accepted and reported as dropped.
`include "assert_macros.svh"

module fastcgi_record_session_deframer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  fcrd_in_if.sink    in_i,
  fcrd_out_if.source out_o
);

  logic [7:0] exp_ver_q, acc_role_q;

  fcrd_pkg::phase_e phase_q, phase_d;
  logic [15:0] byte_count_q, byte_count_d;
  logic [7:0]  hdr_version_q, hdr_version_d;
  logic [7:0]  cur_type_q, cur_type_d;
  logic [15:0] cur_id_q, cur_id_d;
  logic [15:0] content_len_q, content_len_d;
  logic [7:0]  pad_len_q, pad_len_d;
  logic [7:0]  role_high_q, role_high_d;
  logic [7:0]  role_low_q, role_low_d;
  logic [7:0]  begin_flags_q, begin_flags_d;
  logic        session_open_q, session_open_d;
  logic [15:0] session_id_q, session_id_d;
  logic        session_keep_q, session_keep_d;
  logic        stopped_q, stopped_d;
  logic        version_err_q, version_err_d;

  logic        out_valid_q;
  fcrd_pkg::result_t res_q, res_d;

  logic        in_acc;
  logic [7:0]  b;
  logic [2:0]  kind;
  logic        last, started, done, rec_end, show;
  logic [15:0] cnt_inc;
  logic [2:0]  hdr_idx;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign cnt_inc    = byte_count_q + 16'd1;
  assign hdr_idx    = byte_count_q[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_ver_q  <= fcrd_pkg::EXPECTED_VERSION_RST;
      acc_role_q <= fcrd_pkg::ACCEPTED_ROLE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fcrd_pkg::REG_EXPECTED_VERSION) begin
        exp_ver_q <= cfg_data_i;
      end else begin
        acc_role_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    phase_d        = phase_q;
    byte_count_d   = byte_count_q;
    hdr_version_d  = hdr_version_q;
    cur_type_d     = cur_type_q;
    cur_id_d       = cur_id_q;
    content_len_d  = content_len_q;
    pad_len_d      = pad_len_q;
    role_high_d    = role_high_q;
    role_low_d     = role_low_q;
    begin_flags_d  = begin_flags_q;
    session_open_d = session_open_q;
    session_id_d   = session_id_q;
    session_keep_d = session_keep_q;
    stopped_d      = stopped_q;
    version_err_d  = version_err_q;
    kind           = fcrd_pkg::KIND_DROPPED;
    last           = 1'b0;
    started        = 1'b0;
    done           = 1'b0;
    rec_end        = 1'b0;

    if (!stopped_q) begin
      case (phase_q)
        fcrd_pkg::PH_CONTENT: begin
          kind = fcrd_pkg::KIND_IGNORED;
          if (session_open_q && cur_id_q == session_id_q) begin
            if (cur_type_q == fcrd_pkg::TYPE_PARAMS) begin
              kind = fcrd_pkg::KIND_PARAMS;
            end else if (cur_type_q == fcrd_pkg::TYPE_STDIN) begin
              kind = fcrd_pkg::KIND_STDIN;
            end
          end
          if (byte_count_q == 16'd0) begin
            role_high_d = b;
          end else if (byte_count_q == 16'd1) begin
            role_low_d = b;
          end else if (byte_count_q == 16'd2) begin
            begin_flags_d = b;
          end
          byte_count_d = cnt_inc;
          if (cnt_inc >= content_len_q) begin
            last         = 1'b1;
            byte_count_d = 16'd0;
            if (pad_len_q != 8'd0) begin
              phase_d = fcrd_pkg::PH_PADDING;
            end else begin
              phase_d = fcrd_pkg::PH_HEADER;
              rec_end = 1'b1;
            end
          end
        end
        fcrd_pkg::PH_PADDING: begin
          kind         = fcrd_pkg::KIND_PADDING;
          byte_count_d = cnt_inc;
          if (cnt_inc >= {8'd0, pad_len_q}) begin
            byte_count_d = 16'd0;
            phase_d      = fcrd_pkg::PH_HEADER;
            rec_end      = 1'b1;
          end
        end
        default: begin
          // header phase; the unused codes land here too
          kind    = fcrd_pkg::KIND_HEADER;
          phase_d = fcrd_pkg::PH_HEADER;
          case (hdr_idx)
            3'd0: begin
              hdr_version_d = b;
              cur_type_d    = 8'd0;
            end
            3'd1:    cur_type_d = b;
            3'd2:    cur_id_d = {b, cur_id_q[7:0]};
            3'd3:    cur_id_d = {cur_id_q[15:8], b};
            3'd4:    content_len_d = {b, content_len_q[7:0]};
            3'd5:    content_len_d = {content_len_q[15:8], b};
            3'd6:    pad_len_d = b;
            default: ;
          endcase
          if (hdr_idx == fcrd_pkg::HDR_LAST_IDX) begin
            byte_count_d = 16'd0;
            if (hdr_version_d != exp_ver_q) begin
              version_err_d = 1'b1;
              stopped_d     = 1'b1;
            end else if (content_len_d != 16'd0) begin
              phase_d = fcrd_pkg::PH_CONTENT;
            end else if (pad_len_d != 8'd0) begin
              phase_d = fcrd_pkg::PH_PADDING;
            end else begin
              rec_end = 1'b1;
            end
          end else begin
            byte_count_d = {13'd0, hdr_idx + 3'd1};
          end
        end
      endcase

      if (rec_end) begin
        if (!session_open_q) begin
          if (cur_type_d == fcrd_pkg::TYPE_BEGIN_REQUEST &&
              content_len_d == fcrd_pkg::BEGIN_BODY_LEN &&
              role_high_d == 8'd0 && role_low_d == acc_role_q) begin
            session_open_d = 1'b1;
            session_id_d   = cur_id_d;
            session_keep_d = begin_flags_d[fcrd_pkg::FCGI_KEEP_CONN_BIT];
            started        = 1'b1;
          end
        end else if (cur_type_d == fcrd_pkg::TYPE_STDIN && cur_id_d == session_id_q &&
                     content_len_d == 16'd0) begin
          done           = 1'b1;
          session_open_d = 1'b0;
          if (!session_keep_q) begin
            stopped_d = 1'b1;
          end
        end
      end
    end

    show = session_open_d || done;
    res_d.byte_kind          = kind;
    res_d.data_out           = b;
    res_d.session_request_id = show ? session_id_d : 16'd0;
    res_d.record_kind        = cur_type_d;
    res_d.last_content       = last;
    res_d.session_started    = started;
    res_d.keep_connection    = show && session_keep_d;
    res_d.request_done       = done;
    res_d.version_error      = version_err_d;
    res_d.connection_closed  = stopped_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= fcrd_pkg::PH_HEADER;
      byte_count_q   <= 16'd0;
      hdr_version_q  <= 8'd0;
      cur_type_q     <= 8'd0;
      cur_id_q       <= 16'd0;
      content_len_q  <= 16'd0;
      pad_len_q      <= 8'd0;
      role_high_q    <= 8'd0;
      role_low_q     <= 8'd0;
      begin_flags_q  <= 8'd0;
      session_open_q <= 1'b0;
      session_id_q   <= 16'd0;
      session_keep_q <= 1'b0;
      stopped_q      <= 1'b0;
      version_err_q  <= 1'b0;
    end else if (in_acc) begin
      phase_q        <= phase_d;
      byte_count_q   <= byte_count_d;
      hdr_version_q  <= hdr_version_d;
      cur_type_q     <= cur_type_d;
      cur_id_q       <= cur_id_d;
      content_len_q  <= content_len_d;
      pad_len_q      <= pad_len_d;
      role_high_q    <= role_high_d;
      role_low_q     <= role_low_d;
      begin_flags_q  <= begin_flags_d;
      session_open_q <= session_open_d;
      session_id_q   <= session_id_d;
      session_keep_q <= session_keep_d;
      stopped_q      <= stopped_d;
      version_err_q  <= version_err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.byte_kind          = res_q.byte_kind;
  assign out_o.data_out           = res_q.data_out;
  assign out_o.session_request_id = res_q.session_request_id;
  assign out_o.record_kind        = res_q.record_kind;
  assign out_o.last_content       = res_q.last_content;
  assign out_o.session_started    = res_q.session_started;
  assign out_o.keep_connection    = res_q.keep_connection;
  assign out_o.request_done       = res_q.request_done;
  assign out_o.version_error      = res_q.version_error;
  assign out_o.connection_closed  = res_q.connection_closed;

  `FCRD_ASSERT_NEXT(a_stop_sticky, stopped_q, stopped_q)
  `FCRD_ASSERT_IMPL(a_err_stops, version_err_q, stopped_q)
  `FCRD_ASSERT_NEXT(a_drop_when_stopped, in_acc && stopped_q,
                    out_valid_q && res_q.byte_kind == fcrd_pkg::KIND_DROPPED)
  `FCRD_ASSERT(a_start_done_excl,
               !(out_valid_q && res_q.session_started && res_q.request_done))

endmodule

// ----- dv/fastcgi_record_session_deframer_top_tb.sv -----
// Testbench for the FastCGI record session deframer: framed record streams, scoreboard check.
`timescale 1ns / 1ps

module fastcgi_record_session_deframer_top_tb;

  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;

  fcrd_in_if  in_if ();
  fcrd_out_if out_if ();

  fastcgi_record_session_deframer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // register copies
  logic [7:0]  cfg_version = fcrd_pkg::EXPECTED_VERSION_RST;
  logic [7:0]  cfg_role    = fcrd_pkg::ACCEPTED_ROLE_RST;

  // parser and session tracker state
  fcrd_pkg::phase_e trk_phase = fcrd_pkg::PH_HEADER;
  logic [15:0] trk_count   = '0;
  logic [7:0]  trk_version = '0;
  logic [7:0]  trk_type    = '0;
  logic [15:0] trk_cur_id  = '0;
  logic [15:0] trk_clen    = '0;
  logic [7:0]  trk_plen    = '0;
  logic [7:0]  trk_role_hi = '0;
  logic [7:0]  trk_role_lo = '0;
  logic [7:0]  trk_flags   = '0;
  logic        trk_open    = 1'b0;
  logic [15:0] trk_sess_id = '0;
  logic        trk_keep    = 1'b0;
  logic        trk_stopped = 1'b0;
  logic        trk_ver_bad = 1'b0;

  fcrd_pkg::result_t expected_words[$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt  = 0;
  bit          no_idle    = 1'b0;

  function automatic fcrd_pkg::result_t classify_byte(input logic [7:0] b);
    fcrd_pkg::result_t r;
    logic [2:0] kind;
    logic       last;
    logic       started;
    logic       done;
    logic       rec_end;
    logic       show;
    kind    = fcrd_pkg::KIND_DROPPED;
    last    = 1'b0;
    started = 1'b0;
    done    = 1'b0;
    rec_end = 1'b0;
    if (!trk_stopped) begin
      if (trk_phase == fcrd_pkg::PH_CONTENT) begin
        kind = fcrd_pkg::KIND_IGNORED;
        if (trk_open && trk_cur_id == trk_sess_id) begin
          if (trk_type == fcrd_pkg::TYPE_PARAMS) kind = fcrd_pkg::KIND_PARAMS;
          else if (trk_type == fcrd_pkg::TYPE_STDIN) kind = fcrd_pkg::KIND_STDIN;
        end
        // the first three content bytes of any record feed the begin body
        case (trk_count)
          16'd0: trk_role_hi = b;
          16'd1: trk_role_lo = b;
          16'd2: trk_flags = b;
          default: ;
        endcase
        trk_count = trk_count + 16'd1;
        if (trk_count >= trk_clen) begin
          last      = 1'b1;
          trk_count = '0;
          if (trk_plen != 8'd0) begin
            trk_phase = fcrd_pkg::PH_PADDING;
          end else begin
            trk_phase = fcrd_pkg::PH_HEADER;
            rec_end   = 1'b1;
          end
        end
      end else if (trk_phase == fcrd_pkg::PH_PADDING) begin
        kind      = fcrd_pkg::KIND_PADDING;
        trk_count = trk_count + 16'd1;
        if (trk_count >= {8'd0, trk_plen}) begin
          trk_count = '0;
          trk_phase = fcrd_pkg::PH_HEADER;
          rec_end   = 1'b1;
        end
      end else begin
        kind      = fcrd_pkg::KIND_HEADER;
        trk_phase = fcrd_pkg::PH_HEADER;
        case (trk_count[2:0])
          3'd0: begin
            trk_version = b;
            trk_type    = 8'd0;
          end
          3'd1: trk_type = b;
          3'd2: trk_cur_id[15:8] = b;
          3'd3: trk_cur_id[7:0] = b;
          3'd4: trk_clen[15:8] = b;
          3'd5: trk_clen[7:0] = b;
          3'd6: trk_plen = b;
          default: ;
        endcase
        if (trk_count[2:0] == fcrd_pkg::HDR_LAST_IDX) begin
          trk_count = '0;
          if (trk_version != cfg_version) begin
            trk_ver_bad = 1'b1;
            trk_stopped = 1'b1;
          end else if (trk_clen != 16'd0) begin
            trk_phase = fcrd_pkg::PH_CONTENT;
          end else if (trk_plen != 8'd0) begin
            trk_phase = fcrd_pkg::PH_PADDING;
          end else begin
            rec_end = 1'b1;
          end
        end else begin
          trk_count = {13'd0, trk_count[2:0]} + 16'd1;
        end
      end

      if (rec_end) begin
        if (!trk_open) begin
          if (trk_type == fcrd_pkg::TYPE_BEGIN_REQUEST &&
              trk_clen == fcrd_pkg::BEGIN_BODY_LEN &&
              trk_role_hi == 8'd0 && trk_role_lo == cfg_role) begin
            trk_open    = 1'b1;
            trk_sess_id = trk_cur_id;
            trk_keep    = trk_flags[fcrd_pkg::FCGI_KEEP_CONN_BIT];
            started     = 1'b1;
          end
        end else if (trk_type == fcrd_pkg::TYPE_STDIN && trk_cur_id == trk_sess_id &&
                     trk_clen == 16'd0) begin
          done     = 1'b1;
          trk_open = 1'b0;
          if (!trk_keep) trk_stopped = 1'b1;
        end
      end
    end

    show                 = trk_open || done;
    r.byte_kind          = kind;
    r.data_out           = b;
    r.session_request_id = show ? trk_sess_id : 16'd0;
    r.record_kind        = trk_type;
    r.last_content       = last;
    r.session_started    = started;
    r.keep_connection    = show && trk_keep;
    r.request_done       = done;
    r.version_error      = trk_ver_bad;
    r.connection_closed  = trk_stopped;
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] rand_id();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return 16'h0000;
    if (pick < 30) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_word();
    fcrd_pkg::result_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual data_out %0h",
               $time, out_if.data_out);
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      check_field("byte_kind", 16'(want.byte_kind), 16'(out_if.byte_kind));
      check_field("data_out", 16'(want.data_out), 16'(out_if.data_out));
      check_field("session_request_id", want.session_request_id,
                  out_if.session_request_id);
      check_field("record_kind", 16'(want.record_kind), 16'(out_if.record_kind));
      check_field("last_content", 16'(want.last_content), 16'(out_if.last_content));
      check_field("session_started", 16'(want.session_started),
                  16'(out_if.session_started));
      check_field("keep_connection", 16'(want.keep_connection),
                  16'(out_if.keep_connection));
      check_field("request_done", 16'(want.request_done), 16'(out_if.request_done));
      check_field("version_error", 16'(want.version_error), 16'(out_if.version_error));
      check_field("connection_closed", 16'(want.connection_closed),
                  16'(out_if.connection_closed));
    end
  endtask

  // result side: random stalls, check every taken word
  initial begin
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) compare_word();
      out_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expected_words.push_back(classify_byte(b));
    bytes_sent++;
  endtask

  // drop valid and hold until every predicted word has been taken
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fcrd_pkg::REG_EXPECTED_VERSION) cfg_version = val;
    else cfg_role = val;
  endtask

  task automatic set_config(input logic [7:0] ver, input logic [7:0] role);
    write_reg(fcrd_pkg::REG_EXPECTED_VERSION, ver);
    write_reg(fcrd_pkg::REG_ACCEPTED_ROLE, role);
  endtask

  task automatic emit_record(input logic [7:0] ver, input logic [7:0] rtype,
                             input logic [15:0] rid, input logic [15:0] clen,
                             input logic [7:0] plen, input logic [7:0] role_hi,
                             input logic [7:0] role_lo, input logic [7:0] flags);
    int unsigned i;
    push_byte(ver);
    push_byte(rtype);
    push_byte(rid[15:8]);
    push_byte(rid[7:0]);
    push_byte(clen[15:8]);
    push_byte(clen[7:0]);
    push_byte(plen);
    push_byte(rand_byte());
    for (i = 0; i < clen; i++) begin
      if (i == 0) push_byte(role_hi);
      else if (i == 1) push_byte(role_lo);
      else if (i == 2) push_byte(flags);
      else push_byte(rand_byte());
    end
    for (i = 0; i < plen; i++) push_byte(rand_byte());
  endtask

  task automatic begin_request(input logic [15:0] rid, input logic [7:0] flags,
                               input logic [7:0] plen);
    emit_record(cfg_version, fcrd_pkg::TYPE_BEGIN_REQUEST, rid, fcrd_pkg::BEGIN_BODY_LEN,
                plen, 8'h00, cfg_role, flags);
  endtask

  // any type but begin request, so a stray body never opens a session
  task automatic emit_other_record();
    logic [7:0] rtype;
    rtype = rand_byte();
    if (rtype == fcrd_pkg::TYPE_BEGIN_REQUEST) rtype = 8'h00;
    emit_record(cfg_version, rtype, rand_id(), 16'($urandom_range(10)),
                8'($urandom_range(5)), rand_byte(), rand_byte(), rand_byte());
  endtask

  task automatic test_directed_records();
    begin_request(16'hFFFF, 8'hFF, 8'd0);
    // begin request inside a session: body counts as ignored
    begin_request(16'h0001, 8'h01, 8'd1);
    emit_record(cfg_version, fcrd_pkg::TYPE_PARAMS, 16'hFFFF, 16'd2, 8'd0, 8'h00,
                8'hFF, 8'h00);
    emit_record(cfg_version, fcrd_pkg::TYPE_STDIN, 16'h0000, 16'd1, 8'd0, 8'hFF,
                8'h00, 8'h00);
    emit_record(cfg_version, fcrd_pkg::TYPE_STDIN, 16'hFFFF, 16'd1, 8'd2, 8'h00,
                8'h00, 8'h00);
    // empty stdin with no padding ends the request on the last header byte
    emit_record(cfg_version, fcrd_pkg::TYPE_STDIN, 16'hFFFF, 16'd0, 8'd0, 8'h00,
                8'h00, 8'h00);
  endtask

  task automatic test_random_records(input int unsigned byte_goal, input bit calm,
                                     input bit pause_midway);
    int unsigned start;
    int unsigned r;
    bit          paused;
    logic [15:0] clen;
    no_idle = calm;
    start   = bytes_sent;
    paused  = 1'b0;
    while (bytes_sent - start < byte_goal) begin
      if (pause_midway && !paused && bytes_sent - start >= byte_goal / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      if (!trk_open) begin
        if (r < 55) begin
          begin_request(rand_id(), rand_byte() | 8'h01, 8'($urandom_range(3)));
        end else if (r < 62) begin
          emit_record(cfg_version, fcrd_pkg::TYPE_BEGIN_REQUEST, rand_id(),
                      fcrd_pkg::BEGIN_BODY_LEN, 8'd0, 8'($urandom_range(255, 1)),
                      cfg_role, rand_byte() | 8'h01);
        end else if (r < 69) begin
          emit_record(cfg_version, fcrd_pkg::TYPE_BEGIN_REQUEST, rand_id(),
                      fcrd_pkg::BEGIN_BODY_LEN, 8'd1, 8'h00, cfg_role + 8'd1,
                      rand_byte() | 8'h01);
        end else if (r < 76) begin
          clen = 16'($urandom_range(12, 3));
          if (clen == fcrd_pkg::BEGIN_BODY_LEN) clen = 16'd9;
          emit_record(cfg_version, fcrd_pkg::TYPE_BEGIN_REQUEST, rand_id(), clen, 8'd0,
                      8'h00, cfg_role, rand_byte() | 8'h01);
        end else begin
          emit_other_record();
        end
      end else begin
        if (r < 35) begin
          emit_record(cfg_version, fcrd_pkg::TYPE_PARAMS, trk_sess_id,
                      16'($urandom_range(12, 1)), 8'($urandom_range(4)), rand_byte(),
                      rand_byte(), rand_byte());
        end else if (r < 60) begin
          emit_record(cfg_version, fcrd_pkg::TYPE_STDIN, trk_sess_id,
                      16'($urandom_range(12, 1)), 8'($urandom_range(4)), rand_byte(),
                      rand_byte(), rand_byte());
        end else if (r < 75) begin
          emit_record(cfg_version, fcrd_pkg::TYPE_STDIN, trk_sess_id, 16'd0,
                      8'($urandom_range(3)), 8'h00, 8'h00, 8'h00);
        end else if (r < 85) begin
          begin_request(rand_id(), rand_byte() | 8'h01, 8'($urandom_range(2)));
        end else begin
          emit_other_record();
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // content length past one byte of count, with a wide padding run
  task automatic test_long_record();
    emit_record(cfg_version, 8'hFF, rand_id(), 16'h0101, 8'h40, rand_byte(),
                rand_byte(), rand_byte());
  endtask

  // the block stops for good here: either a bad version or a request without keep
  task automatic test_shutdown();
    int unsigned i;
    if ($urandom_range(1) == 0) begin
      emit_record(cfg_version ^ 8'($urandom_range(255, 1)), fcrd_pkg::TYPE_PARAMS,
                  rand_id(), 16'd4, 8'd2, rand_byte(), rand_byte(), rand_byte());
    end else begin
      if (trk_open)
        emit_record(cfg_version, fcrd_pkg::TYPE_STDIN, trk_sess_id, 16'd0, 8'd0, 8'h00,
                    8'h00, 8'h00);
      begin_request(rand_id(), rand_byte() & 8'hFE, 8'd1);
      emit_record(cfg_version, fcrd_pkg::TYPE_PARAMS, trk_sess_id, 16'd3, 8'd0,
                  rand_byte(), rand_byte(), rand_byte());
      emit_record(cfg_version, fcrd_pkg::TYPE_STDIN, trk_sess_id, 16'd0, 8'd0, 8'h00,
                  8'h00, 8'h00);
    end
    for (i = 0; i < 24; i++) push_byte(rand_byte());
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = fcrd_pkg::REG_EXPECTED_VERSION;
    cfg_data_i      = 8'd0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'd0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_records();
    test_random_records(180, 1'b0, 1'b0);
    set_config(8'd0, 8'd0);
    test_random_records(140, 1'b1, 1'b0);
    test_long_record();
    set_config(8'd255, 8'd255);
    test_random_records(140, 1'b0, 1'b1);
    set_config(rand_byte(), rand_byte());
    test_random_records(180, 1'b0, 1'b0);
    test_shutdown();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- fastcgi_record_session_deframer_top.f -----
+incdir+hdl
hdl/fcrd_pkg.sv
hdl/fcrd_if.sv
hdl/fastcgi_record_session_deframer_top.sv
dv/fastcgi_record_session_deframer_top_tb.sv
